// ===== hdl/escd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escd_pkg
// types, character codes and the decimal digit helper of the line decoder
// ----------------------------------------------------------------------------
package escd_pkg;

  localparam int unsigned MaxBeats = 6;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_OCT1 = 2'd2,
    MODE_OCT2 = 2'd3
  } escd_mode_t;

  // expansion of one input byte, beat 0 goes out first
  typedef struct packed {
    logic [MaxBeats-1:0][7:0] bytes;
    logic [2:0]               cnt;
  } escd_exp_t;

  typedef struct packed {
    logic [2:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } escd_dec_t;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_N = 8'h6e;
  localparam logic [7:0] CH_LOW_R = 8'h72;
  localparam logic [7:0] CH_LOW_T = 8'h74;

  // 0..511 into decimal digits with parallel constant compares
  function automatic escd_dec_t to_decimal(logic [8:0] v);
    escd_dec_t  d;
    logic [8:0] rem;
    d.hundreds = 3'd0;
    for (int k = 1; k <= 5; k++) begin
      if (v >= 9'(k * 100)) d.hundreds = 3'(k);
    end
    rem = v - 9'(d.hundreds) * 9'd100;
    d.tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem >= 9'(k * 10)) d.tens = 4'(k);
    end
    d.ones = 4'(rem - 9'(d.tens) * 9'd10);
    return d;
  endfunction

endpackage

// ===== hdl/escd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escd_in_if
// input channel: one raw byte of the escaped line per beat
// ----------------------------------------------------------------------------
interface escd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== hdl/escd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escd_out_if
// result channel: one decoded byte per beat
// ----------------------------------------------------------------------------
interface escd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== hdl/escd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escd_decode
// escape state machine and expansion of one input byte into up to six bytes
// ----------------------------------------------------------------------------
module escd_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               entity_en,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  output escd_pkg::escd_exp_t exp
);

  escd_pkg::escd_mode_t mode_r, mode_nxt;
  logic [2:0]           d1_r, d1_nxt;
  logic [2:0]           d2_r, d2_nxt;
  logic                 is_oct;
  escd_pkg::escd_dec_t  dec;

  assign is_oct = (in_byte[7:3] == 5'b00110);
  assign dec    = escd_pkg::to_decimal({d1_r, d2_r, in_byte[2:0]});

  // next state
  always_comb begin
    mode_nxt = mode_r;
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    case (mode_r)
      escd_pkg::MODE_TEXT: begin
        if (in_byte == escd_pkg::CH_BSL) mode_nxt = escd_pkg::MODE_ESC;
      end
      escd_pkg::MODE_ESC: begin
        if (is_oct && in_byte != escd_pkg::CH_LF) begin
          mode_nxt = escd_pkg::MODE_OCT1;
          d1_nxt   = in_byte[2:0];
        end else begin
          mode_nxt = escd_pkg::MODE_TEXT;
        end
      end
      escd_pkg::MODE_OCT1: begin
        if (is_oct) begin
          mode_nxt = escd_pkg::MODE_OCT2;
          d2_nxt   = in_byte[2:0];
        end else begin
          mode_nxt = escd_pkg::MODE_TEXT;
        end
      end
      escd_pkg::MODE_OCT2: begin
        mode_nxt = escd_pkg::MODE_TEXT;
      end
      default: mode_nxt = escd_pkg::MODE_TEXT;
    endcase
  end

  // expansion
  always_comb begin
    exp.bytes = '0;
    exp.cnt   = 3'd0;
    case (mode_r)
      escd_pkg::MODE_TEXT: begin
        if (in_byte == escd_pkg::CH_LF || in_byte == escd_pkg::CH_BSL) begin
          exp.cnt = 3'd0;
        end else if (entity_en && in_byte == escd_pkg::CH_LT) begin
          exp.bytes[0] = escd_pkg::CH_AMP;
          exp.bytes[1] = "l";
          exp.bytes[2] = "t";
          exp.bytes[3] = escd_pkg::CH_SEMI;
          exp.cnt      = 3'd4;
        end else if (entity_en && in_byte == escd_pkg::CH_GT) begin
          exp.bytes[0] = escd_pkg::CH_AMP;
          exp.bytes[1] = "g";
          exp.bytes[2] = "t";
          exp.bytes[3] = escd_pkg::CH_SEMI;
          exp.cnt      = 3'd4;
        end else if (entity_en && in_byte == escd_pkg::CH_QUOT) begin
          exp.bytes[0] = escd_pkg::CH_AMP;
          exp.bytes[1] = "q";
          exp.bytes[2] = "u";
          exp.bytes[3] = "o";
          exp.bytes[4] = "t";
          exp.bytes[5] = escd_pkg::CH_SEMI;
          exp.cnt      = 3'd6;
        end else if (entity_en && in_byte == escd_pkg::CH_AMP) begin
          exp.bytes[0] = escd_pkg::CH_AMP;
          exp.bytes[1] = "a";
          exp.bytes[2] = "m";
          exp.bytes[3] = "p";
          exp.bytes[4] = escd_pkg::CH_SEMI;
          exp.cnt      = 3'd5;
        end else if (entity_en && in_byte == escd_pkg::CH_APOS) begin
          exp.bytes[0] = escd_pkg::CH_AMP;
          exp.bytes[1] = "a";
          exp.bytes[2] = "p";
          exp.bytes[3] = "o";
          exp.bytes[4] = "s";
          exp.bytes[5] = escd_pkg::CH_SEMI;
          exp.cnt      = 3'd6;
        end else begin
          exp.bytes[0] = in_byte;
          exp.cnt      = 3'd1;
        end
      end
      escd_pkg::MODE_ESC: begin
        if (in_byte == escd_pkg::CH_LF || is_oct) begin
          exp.cnt = 3'd0;
        end else if (in_byte == escd_pkg::CH_LOW_N) begin
          exp.bytes[0] = escd_pkg::CH_LF;
          exp.cnt      = 3'd1;
        end else if (in_byte == escd_pkg::CH_LOW_R) begin
          exp.bytes[0] = escd_pkg::CH_CR;
          exp.cnt      = 3'd1;
        end else if (in_byte == escd_pkg::CH_LOW_T) begin
          exp.bytes[0] = escd_pkg::CH_TAB;
          exp.cnt      = 3'd1;
        end else if (in_byte == escd_pkg::CH_HASH) begin
          exp.bytes[0] = escd_pkg::CH_AMP;
          exp.bytes[1] = escd_pkg::CH_HASH;
          exp.cnt      = 3'd2;
        end else begin
          exp.bytes[0] = in_byte;
          exp.cnt      = 3'd1;
        end
      end
      escd_pkg::MODE_OCT1: begin
        if (!is_oct) begin
          exp.bytes[0] = escd_pkg::CH_ZERO | {5'd0, d1_r};
          exp.bytes[1] = in_byte;
          exp.cnt      = 3'd2;
        end
      end
      escd_pkg::MODE_OCT2: begin
        if (is_oct) begin
          exp.bytes[0] = escd_pkg::CH_AMP;
          exp.bytes[1] = escd_pkg::CH_HASH;
          // no leading zeros
          if (dec.hundreds != 3'd0) begin
            exp.bytes[2] = escd_pkg::CH_ZERO | {5'd0, dec.hundreds};
            exp.bytes[3] = escd_pkg::CH_ZERO | {4'd0, dec.tens};
            exp.bytes[4] = escd_pkg::CH_ZERO | {4'd0, dec.ones};
            exp.bytes[5] = escd_pkg::CH_SEMI;
            exp.cnt      = 3'd6;
          end else if (dec.tens != 4'd0) begin
            exp.bytes[2] = escd_pkg::CH_ZERO | {4'd0, dec.tens};
            exp.bytes[3] = escd_pkg::CH_ZERO | {4'd0, dec.ones};
            exp.bytes[4] = escd_pkg::CH_SEMI;
            exp.cnt      = 3'd5;
          end else begin
            exp.bytes[2] = escd_pkg::CH_ZERO | {4'd0, dec.ones};
            exp.bytes[3] = escd_pkg::CH_SEMI;
            exp.cnt      = 3'd4;
          end
        end else begin
          exp.bytes[0] = escd_pkg::CH_ZERO | {5'd0, d1_r};
          exp.bytes[1] = escd_pkg::CH_ZERO | {5'd0, d2_r};
          exp.bytes[2] = in_byte;
          exp.cnt      = 3'd3;
        end
      end
      default: exp.cnt = 3'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= escd_pkg::MODE_TEXT;
      d1_r   <= 3'd0;
      d2_r   <= 3'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
    end
  end

endmodule

// ===== hdl/escd_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escd_out_buf
// result register holding one expansion and draining it a beat at a time
// ----------------------------------------------------------------------------
module escd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  escd_pkg::escd_exp_t exp,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  logic [escd_pkg::MaxBeats-1:0][7:0] bytes_r;
  logic [2:0]                         cnt_r;
  logic [2:0]                         idx_r;

  assign out_valid = (cnt_r != 3'd0);
  assign out_byte  = bytes_r[idx_r];
  assign out_last  = (idx_r == cnt_r - 3'd1);
  // refill once the final beat leaves
  assign can_load  = !out_valid || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (load) bytes_r <= exp.bytes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 3'd0;
    end else if (load) begin
      cnt_r <= exp.cnt;
      idx_r <= 3'd0;
    end else if (out_valid && out_ready) begin
      if (out_last) begin
        cnt_r <= 3'd0;
        idx_r <= 3'd0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd6) else $error("expansion count out of range");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> idx_r < cnt_r) else $error("beat index past expansion");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid || (out_ready && out_last)))
    else $error("expansion loaded over pending beats");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last && !load) |=> !out_valid)
    else $error("buffer not empty after final beat");

endmodule

// ===== hdl/escaped_text_line_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_text_line_decoder_unit
// escaped text line decoder with optional markup entity expansion
// ----------------------------------------------------------------------------
// one raw byte is taken per in beat and turned into zero to six decoded
// bytes on the out channel, the final one of each input byte flagged with
// last. while the out channel is ready, a byte that decodes to one output
// beat is accepted every cycle, so plain text streams at one byte per clock;
// an expansion of n bytes holds the input channel while the result register
// drains its n beats, and a byte that yields nothing (newline, backslash,
// pending octal digit) loads no beat. the next input is taken in the same
// cycle as the final beat of the previous expansion leaves. cfg_we writes
// entity_escape_enable from cfg_wdata; write it only while the block is idle
module escaped_text_line_decoder_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  escd_in_if.sink       in_chan,
  escd_out_if.source    out_chan
);

  logic                entity_en_r;
  logic                accept;
  logic                can_load;
  escd_pkg::escd_exp_t exp;

  // entity escape enable, the user must touch it only between lines; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entity_en_r <= 1'b0;
    end else if (cfg_we) begin
      entity_en_r <= cfg_wdata;
    end
  end

  // a byte is taken whenever the result register is free or freeing
  assign in_chan.ready = can_load;
  assign accept        = in_chan.valid && can_load;

  // escape state machine and per-byte expansion
  escd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .entity_en (entity_en_r),
    .accept    (accept),
    .in_byte   (in_chan.in_byte),
    .exp       (exp)
  );

  // result register, one decoded byte per beat
  escd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .exp       (exp),
    .can_load  (can_load),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_byte  (out_chan.out_byte),
    .out_last  (out_chan.last)
  );

endmodule

// ===== bench/escaped_text_line_decoder_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_text_line_decoder_unit_test
// self-checking bench for the escaped text line decoder
// ----------------------------------------------------------------------------
// raw line bytes are pushed into the input channel under random gaps while
// the result channel stalls at random. every accepted input byte runs
// through a behavioral decoder held here, which queues the decoded beats it
// should cause; each result beat is checked against the oldest queued one,
// byte and last flag both. a directed part walks plain text, markup
// entities, every escape and the octal corner cases, then random runs of
// well-formed escapes mixed with noise go through under both settings
// of the entity enable, one run with no idling on either side
module escaped_text_line_decoder_unit_test;

  localparam int unsigned IdlePct    = 29;   // percent of cycles a side idles
  localparam int unsigned DrainWait  = 12;   // cycles after the last beat
  localparam int unsigned StuckLimit = 2000; // cycles with no beat at all

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  escd_in_if  in_if ();
  escd_out_if out_if ();

  escaped_text_line_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // decoded beats still owed by the block, oldest first
  dec_beat_t  decoded_q[$];
  int         errors;
  bit         no_idle;
  int unsigned stuck_cycles = 0;

  // shadow copy of the decoder state and the enable register
  escd_pkg::escd_mode_t pred_mode;
  logic [2:0] pred_first;
  logic [2:0] pred_second;
  logic       pred_entity_on;

  // work out the beats one raw byte causes and queue them
  function automatic void predict_decode(input logic [7:0] b);
    logic [7:0] outs[$];
    string      ent;
    int         v;
    logic       is_oct;
    is_oct = (b >= escd_pkg::CH_ZERO) && (b <= escd_pkg::CH_ZERO + 8'd7);
    ent = "";
    case (pred_mode)
      escd_pkg::MODE_TEXT: begin
        if (b == escd_pkg::CH_BSL) begin
          pred_mode = escd_pkg::MODE_ESC;
        end else if (b != escd_pkg::CH_LF) begin
          // newline in plain text just ends the line
          if (pred_entity_on) begin
            case (b)
              escd_pkg::CH_LT:   ent = "&lt;";
              escd_pkg::CH_GT:   ent = "&gt;";
              escd_pkg::CH_QUOT: ent = "&quot;";
              escd_pkg::CH_AMP:  ent = "&amp;";
              escd_pkg::CH_APOS: ent = "&apos;";
              default:           ent = "";
            endcase
          end
          if (ent.len() > 0) begin
            for (int i = 0; i < ent.len(); i++) outs.push_back(ent[i]);
          end else begin
            outs.push_back(b);
          end
        end
      end
      escd_pkg::MODE_ESC: begin
        pred_mode = escd_pkg::MODE_TEXT;
        if (b == escd_pkg::CH_LOW_N) begin
          outs.push_back(escd_pkg::CH_LF);
        end else if (b == escd_pkg::CH_LOW_R) begin
          outs.push_back(escd_pkg::CH_CR);
        end else if (b == escd_pkg::CH_LOW_T) begin
          outs.push_back(escd_pkg::CH_TAB);
        end else if (b == escd_pkg::CH_HASH) begin
          outs.push_back(escd_pkg::CH_AMP);
          outs.push_back(escd_pkg::CH_HASH);
        end else if (is_oct) begin
          pred_first = b[2:0];
          pred_mode  = escd_pkg::MODE_OCT1;
        end else if (b != escd_pkg::CH_LF) begin
          // escaped byte passes raw, newline aborts the escape
          outs.push_back(b);
        end
      end
      escd_pkg::MODE_OCT1: begin
        if (is_oct) begin
          pred_second = b[2:0];
          pred_mode   = escd_pkg::MODE_OCT2;
        end else begin
          outs.push_back(escd_pkg::CH_ZERO + 8'(pred_first));
          outs.push_back(b);
          pred_mode = escd_pkg::MODE_TEXT;
        end
      end
      default: begin
        if (is_oct) begin
          v = 64 * pred_first + 8 * pred_second + int'(b[2:0]);
          outs.push_back(escd_pkg::CH_AMP);
          outs.push_back(escd_pkg::CH_HASH);
          if (v >= 100) outs.push_back(escd_pkg::CH_ZERO + 8'(v / 100));
          if (v >= 10) outs.push_back(escd_pkg::CH_ZERO + 8'((v / 10) % 10));
          outs.push_back(escd_pkg::CH_ZERO + 8'(v % 10));
          outs.push_back(escd_pkg::CH_SEMI);
        end else begin
          outs.push_back(escd_pkg::CH_ZERO + 8'(pred_first));
          outs.push_back(escd_pkg::CH_ZERO + 8'(pred_second));
          outs.push_back(b);
        end
        pred_mode = escd_pkg::MODE_TEXT;
      end
    endcase
    foreach (outs[i]) decoded_q.push_back('{data: outs[i], last: (i == outs.size() - 1)});
  endfunction

  // input beats feed the shadow decoder, result beats are checked in order
  always @(posedge clk) begin
    dec_beat_t want;
    if (in_if.valid && in_if.ready) predict_decode(in_if.in_byte);
    if (out_if.valid && out_if.ready) begin
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual out_byte=%h last=%b",
                 $time, out_if.out_byte, out_if.last);
      end else begin
        want = decoded_q.pop_front();
        if (out_if.out_byte !== want.data) begin
          errors++;
          $display("%0t: out_byte mismatch, expected %h, actual %h",
                   $time, want.data, out_if.out_byte);
        end
        if (out_if.last !== want.last) begin
          errors++;
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, want.last, out_if.last);
        end
      end
    end
  end

  // result side stalls at random unless idling is off
  always @(negedge clk) begin
    out_if.ready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
  end

  // stop a hung run
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("%0t: no beat for %0d cycles", $time, StuckLimit);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // one raw byte, with an optional random gap in front of it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < IdlePct) gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_escape(input logic [7:0] c);
    send_byte(escd_pkg::CH_BSL);
    send_byte(c);
  endtask

  // drop valid and let every owed beat come out
  task automatic drain;
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // only done with the block idle
  task automatic write_entity_enable(input logic en);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_we    <= 1'b0;
    pred_entity_on = en;
  endtask

  // reset value of the enable: markup goes through raw
  task automatic test_plain_text;
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(escd_pkg::CH_LT);
    send_byte(escd_pkg::CH_LF);
  endtask

  task automatic test_markup_entities;
    write_entity_enable(1'b1);
    send_byte(escd_pkg::CH_LT);
    send_byte(escd_pkg::CH_GT);
    send_byte(escd_pkg::CH_QUOT);
    send_byte(escd_pkg::CH_AMP);
    send_byte(escd_pkg::CH_APOS);
    // escaped markup is never expanded
    send_escape(escd_pkg::CH_LT);
  endtask

  task automatic test_escapes;
    send_escape(escd_pkg::CH_LOW_N);
    send_escape(escd_pkg::CH_LOW_R);
    send_escape(escd_pkg::CH_LOW_T);
    send_escape(escd_pkg::CH_HASH);
    send_escape(escd_pkg::CH_BSL);
    // newline right after a backslash drops the escape
    send_escape(escd_pkg::CH_LF);
  endtask

  task automatic test_octal_refs;
    // largest reference, 511
    send_escape(escd_pkg::CH_ZERO + 8'd7);
    send_byte(escd_pkg::CH_ZERO + 8'd7);
    send_byte(escd_pkg::CH_ZERO + 8'd7);
    // newline after one digit goes out raw
    send_escape(escd_pkg::CH_ZERO + 8'd1);
    send_byte(escd_pkg::CH_LF);
    // backslash after two digits goes out raw and starts nothing
    send_escape(escd_pkg::CH_ZERO + 8'd1);
    send_byte(escd_pkg::CH_ZERO + 8'd2);
    send_byte(escd_pkg::CH_BSL);
  endtask

  // random lines: mostly well-formed escapes with random content, some noise
  task automatic test_random_mix(input logic en, input int items, input bit burst);
    int sent;
    int pick;
    int ndig;
    write_entity_enable(en);
    no_idle = burst;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_byte(8'($urandom_range(0, 255)));
        sent += 1;
      end else if (pick < 35) begin
        case ($urandom_range(0, 4))
          0:       send_byte(escd_pkg::CH_LT);
          1:       send_byte(escd_pkg::CH_GT);
          2:       send_byte(escd_pkg::CH_QUOT);
          3:       send_byte(escd_pkg::CH_AMP);
          default: send_byte(escd_pkg::CH_APOS);
        endcase
        sent += 1;
      end else if (pick < 50) begin
        case ($urandom_range(0, 4))
          0:       send_escape(escd_pkg::CH_LOW_N);
          1:       send_escape(escd_pkg::CH_LOW_R);
          2:       send_escape(escd_pkg::CH_LOW_T);
          3:       send_escape(escd_pkg::CH_HASH);
          default: send_escape(8'($urandom_range(0, 255)));
        endcase
        sent += 2;
      end else if (pick < 72) begin
        send_byte(escd_pkg::CH_BSL);
        repeat (3) send_byte(escd_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
        sent += 4;
      end else if (pick < 85) begin
        // one or two octal digits then a random byte, which usually breaks the run
        ndig = $urandom_range(1, 2);
        send_byte(escd_pkg::CH_BSL);
        repeat (ndig) send_byte(escd_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
        send_byte(8'($urandom_range(0, 255)));
        sent += ndig + 2;
      end else if (pick < 92) begin
        send_byte(escd_pkg::CH_LF);
        sent += 1;
      end else begin
        send_escape(escd_pkg::CH_LF);
        sent += 2;
      end
    end
    drain();
    no_idle = 1'b0;
  endtask

  initial begin
    errors         = 0;
    no_idle        = 1'b0;
    pred_mode      = escd_pkg::MODE_TEXT;
    pred_first     = 3'd0;
    pred_second    = 3'd0;
    pred_entity_on = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_byte  = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_plain_text();
    test_markup_entities();
    test_escapes();
    test_octal_refs();
    test_random_mix(1'b1, 170, 1'b0);
    test_random_mix(1'b0, 150, 1'b1);
    test_random_mix(1'b1, 160, 1'b0);

    if (decoded_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected beats never arrived, next expected %h",
               $time, decoded_q.size(), decoded_q[0].data);
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
